### rtl/lan_pkg.sv
// shared constants, types and helpers of the look-at view matrix block
`default_nettype none
package lan_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int NORM_BITS = 30;

    // unit vector component, rounded row entry, full cross product
    localparam int UW   = FRAC_BITS + 2;
    localparam int RW   = FRAC_BITS + 3;
    localparam int CW   = 2 * FRAC_BITS + 3;
    localparam int VW   = (WORD_BITS + 1 > CW) ? WORD_BITS + 1 : CW;
    localparam int MAGW = (VW > NORM_BITS) ? VW : NORM_BITS;
    localparam int SW   = 2 * NORM_BITS + 2;
    localparam int LW   = NORM_BITS + 1;
    localparam int QW   = FRAC_BITS + 1;
    localparam int NUMW = NORM_BITS + FRAC_BITS + 1;
    localparam int BW   = (WORD_BITS > RW) ? WORD_BITS : RW;
    localparam int PW   = RW + BW;
    localparam int DW   = PW + 2;
    localparam int CNTW = $clog2(NORM_BITS + 1);

    localparam logic signed [DW-1:0] SAT_HI =
        {{(DW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_LO =
        {{(DW - WORD_BITS + 1){1'b1}}, {(WORD_BITS - 1){1'b0}}};

    typedef struct packed {
        logic [2:0][WORD_BITS-1:0] cam;
        logic [2:0][WORD_BITS:0]   d;
        logic [2:0][WORD_BITS-1:0] up;
    } job_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SHIFT,
        NS_SQ,
        NS_ROOT,
        NS_DLOAD,
        NS_DSTEP
    } norm_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_NFWD,
        BS_NUP,
        BS_X1,
        BS_NRIGHT,
        BS_X2,
        BS_DOT,
        BS_EMIT
    } back_state_t;

    function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [DW-1:0] x);
        logic [WORD_BITS-1:0] r;
        if (x > SAT_HI)
            r = SAT_HI[WORD_BITS-1:0];
        else if (x < SAT_LO)
            r = SAT_LO[WORD_BITS-1:0];
        else
            r = x[WORD_BITS-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/lan_in_if.sv
// input channel: camera, target and up vector
`default_nettype none
interface lan_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lan_pkg::WORD_BITS-1:0] cam_x;
    logic signed [lan_pkg::WORD_BITS-1:0] cam_y;
    logic signed [lan_pkg::WORD_BITS-1:0] cam_z;
    logic signed [lan_pkg::WORD_BITS-1:0] target_x;
    logic signed [lan_pkg::WORD_BITS-1:0] target_y;
    logic signed [lan_pkg::WORD_BITS-1:0] target_z;
    logic signed [lan_pkg::WORD_BITS-1:0] up_x;
    logic signed [lan_pkg::WORD_BITS-1:0] up_y;
    logic signed [lan_pkg::WORD_BITS-1:0] up_z;

    modport source (output valid, cam_x, cam_y, cam_z, target_x, target_y, target_z,
                    up_x, up_y, up_z, input ready);
    modport sink (input valid, cam_x, cam_y, cam_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, output ready);
endinterface
`default_nettype wire

### rtl/lan_out_if.sv
// output channel: one matrix row per word
`default_nettype none
interface lan_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           row_index;
    logic signed [lan_pkg::WORD_BITS-1:0] col0;
    logic signed [lan_pkg::WORD_BITS-1:0] col1;
    logic signed [lan_pkg::WORD_BITS-1:0] col2;
    logic signed [lan_pkg::WORD_BITS-1:0] col3;
    logic                                 degenerate;
    logic                                 last_row;

    modport source (output valid, row_index, col0, col1, col2, col3, degenerate, last_row,
                    input ready);
    modport sink (input valid, row_index, col0, col1, col2, col3, degenerate, last_row,
                  output ready);
endinterface
`default_nettype wire

### rtl/lan_front.sv
// front stage: takes input words and forms the camera-to-target difference
`default_nettype none
module lan_front (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lan_in_if.sink      points,
    output lan_pkg::job_t job,
    output logic        job_valid,
    input  wire logic   job_ready
);
    import lan_pkg::*;

    logic sv_reg, sv_next;
    job_t job_reg, job_next;
    logic take;

    assign points.ready = !sv_reg || job_ready;
    assign take         = points.valid && points.ready;
    assign job          = job_reg;
    assign job_valid    = sv_reg;

    always_comb
    begin
        sv_next  = sv_reg;
        job_next = job_reg;
        if (take)
        begin
            sv_next     = 1'b1;
            job_next.cam = {points.cam_z, points.cam_y, points.cam_x};
            job_next.up  = {points.up_z, points.up_y, points.up_x};
            job_next.d[0] = (WORD_BITS+1)'(points.target_x) - (WORD_BITS+1)'(points.cam_x);
            job_next.d[1] = (WORD_BITS+1)'(points.target_y) - (WORD_BITS+1)'(points.cam_y);
            job_next.d[2] = (WORD_BITS+1)'(points.target_z) - (WORD_BITS+1)'(points.cam_z);
        end
        else if (job_ready)
        begin
            sv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= 1'b0;
        else
            sv_reg <= sv_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule
`default_nettype wire

### rtl/lan_queue.sv
// two-entry queue between front and back
`default_nettype none
module lan_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lan_pkg::job_t push_data,
    input  wire logic          push_valid,
    output logic               push_ready,
    output lan_pkg::job_t      pop_data,
    output logic               pop_valid,
    input  wire logic          pop_ready
);
    import lan_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid  = cnt_reg != 2'd0;
    assign pop_data   = mem_reg[rp_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

endmodule
`default_nettype wire

### rtl/lan_norm.sv
// vector normalize unit: scale, sum of squares, bit-serial root, restoring divide
`default_nettype none
module lan_norm (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [2:0][lan_pkg::VW-1:0]      vec,
    output logic                                  done,
    output logic                                  zero,
    output logic [2:0][lan_pkg::UW-1:0]           u
);
    import lan_pkg::*;

    norm_state_t             state_reg, state_next;
    logic                    done_reg, done_next;
    logic                    zero_reg, zero_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic [1:0]              ci_reg, ci_next;
    logic [2:0][MAGW-1:0]    mag_reg, mag_next;
    logic [2:0]              neg_reg, neg_next;
    logic [2*NORM_BITS-1:0]  prod_reg, prod_next;
    logic [SW-1:0]           sum_reg, sum_next;
    logic [SW-1:0]           rn_reg, rn_next;
    logic [SW-1:0]           rr_reg, rr_next;
    logic [SW-1:0]           rb_reg, rb_next;
    logic [LW-1:0]           len_reg, len_next;
    logic [LW-1:0]           rem_reg, rem_next;
    logic [QW-1:0]           nlo_reg, nlo_next;
    logic [QW-1:0]           q_reg, q_next;
    logic [2:0][UW-1:0]      u_reg, u_next;

    logic [2:0][VW-1:0]      absv;
    logic [MAGW-1:0]         or_v;
    logic [NORM_BITS-1:0]    sq_a;
    logic [SW-1:0]           rt_t;
    logic [NUMW-1:0]         num;
    logic [LW:0]             dv_t;
    logic                    qbit;
    logic [QW-1:0]           qf;
    logic [UW-1:0]           qe;

    assign done = done_reg;
    assign zero = zero_reg;
    assign u    = u_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        zero_next  = zero_reg;
        cnt_next   = cnt_reg;
        ci_next    = ci_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        sum_next   = sum_reg;
        rn_next    = rn_reg;
        rr_next    = rr_reg;
        rb_next    = rb_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        nlo_next   = nlo_reg;
        q_next     = q_reg;
        u_next     = u_reg;

        for (int i = 0; i < 3; i++)
            absv[i] = vec[i][VW-1] ? (~vec[i] + 1'b1) : vec[i];
        or_v = mag_reg[0] | mag_reg[1] | mag_reg[2];
        sq_a = (cnt_reg == CNTW'(0)) ? mag_reg[0][NORM_BITS-1:0] :
               (cnt_reg == CNTW'(1)) ? mag_reg[1][NORM_BITS-1:0] :
                                       mag_reg[2][NORM_BITS-1:0];
        rt_t = rr_reg + rb_reg;
        num  = (NUMW'(mag_reg[ci_reg][NORM_BITS-1:0]) << FRAC_BITS) + NUMW'(len_reg >> 1);
        dv_t = {rem_reg, nlo_reg[QW-1]};
        qbit = dv_t >= {1'b0, len_reg};
        qf   = {q_reg[QW-2:0], qbit};
        qe   = UW'(qf);

        unique case (state_reg)
            NS_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = vec[i][VW-1];
                        mag_next[i] = MAGW'(absv[i]);
                    end
                    if (vec == '0)
                    begin
                        u_next    = '0;
                        zero_next = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        zero_next  = 1'b0;
                        state_next = NS_SHIFT;
                    end
                end
            end
            NS_SHIFT:
            begin
                // bring the largest magnitude to exactly NORM_BITS bits
                if ((or_v >> NORM_BITS) != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                end
                else if ((or_v >> (NORM_BITS - 9)) == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] << 8;
                end
                else if (!or_v[NORM_BITS-1])
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] << 1;
                end
                else
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    state_next = NS_SQ;
                end
            end
            NS_SQ:
            begin
                prod_next = sq_a * sq_a;
                if (cnt_reg != CNTW'(0))
                    sum_next = sum_reg + SW'(prod_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(3))
                begin
                    rn_next    = sum_reg + SW'(prod_reg);
                    rr_next    = '0;
                    rb_next    = SW'(1) << (2 * NORM_BITS);
                    cnt_next   = '0;
                    state_next = NS_ROOT;
                end
            end
            NS_ROOT:
            begin
                if (rn_reg >= rt_t)
                begin
                    rn_next = rn_reg - rt_t;
                    rr_next = (rr_reg >> 1) + rb_reg;
                end
                else
                begin
                    rr_next = rr_reg >> 1;
                end
                rb_next  = rb_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NORM_BITS))
                begin
                    len_next   = rr_next[LW-1:0];
                    ci_next    = 2'd0;
                    state_next = NS_DLOAD;
                end
            end
            NS_DLOAD:
            begin
                // quotient fits QW bits, so the top of the numerator is already below len
                rem_next   = LW'(num >> QW);
                nlo_next   = num[QW-1:0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = NS_DSTEP;
            end
            NS_DSTEP:
            begin
                rem_next = qbit ? LW'(dv_t - {1'b0, len_reg}) : dv_t[LW-1:0];
                q_next   = qf;
                nlo_next = nlo_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    u_next[ci_reg] = neg_reg[ci_reg] ? (~qe + 1'b1) : qe;
                    if (ci_reg == 2'd2)
                    begin
                        done_next  = 1'b1;
                        state_next = NS_IDLE;
                    end
                    else
                    begin
                        ci_next    = ci_reg + 1'b1;
                        state_next = NS_DLOAD;
                    end
                end
            end
            default:
            begin
                state_next = NS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= NS_IDLE;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        ci_reg   <= ci_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        rn_reg   <= rn_next;
        rr_reg   <= rr_next;
        rb_reg   <= rb_next;
        len_reg  <= len_next;
        rem_reg  <= rem_next;
        nlo_reg  <= nlo_next;
        q_reg    <= q_next;
        u_reg    <= u_next;
    end

endmodule
`default_nettype wire

### rtl/lan_back.sv
// back sequencer: normalizes, crosses, forms translations and emits the four rows
`default_nettype none
module lan_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lan_pkg::job_t job,
    input  wire logic          job_valid,
    output logic               job_ready,
    lan_out_if.source          rows
);
    import lan_pkg::*;

    back_state_t              state_reg, state_next;
    logic [3:0]               cnt_reg, cnt_next;
    logic [2:0][WORD_BITS-1:0] cam_reg, cam_next;
    logic [2:0][WORD_BITS-1:0] up_reg, up_next;
    logic [2:0][UW-1:0]       fwd_reg, fwd_next;
    logic [2:0][UW-1:0]       upn_reg, upn_next;
    logic [2:0][UW-1:0]       right_reg, right_next;
    logic [2:0][CW-1:0]       c_reg, c_next;
    logic [2:0][2:0][RW-1:0]  row_reg, row_next;
    logic [2:0][WORD_BITS-1:0] col3_reg, col3_next;
    logic                     bad_reg, bad_next;
    logic signed [PW-1:0]     prod_reg, prod_next;
    logic                     pv_reg, pv_next;
    logic [1:0]               pk_reg, pk_next, pi_reg, pi_next;
    logic [1:0]               rk_reg, rk_next, ri_reg, ri_next;
    logic signed [DW-1:0]     acc_reg, acc_next;
    logic [1:0]               er_reg, er_next;

    logic                     ov_reg, ov_next;
    logic [1:0]               oidx_reg, oidx_next;
    logic [3:0][WORD_BITS-1:0] oc_reg, oc_next;
    logic                     odeg_reg, odeg_next, olast_reg, olast_next;

    logic                     n_start, n_done, n_zero;
    logic [2:0][VW-1:0]       n_vec;
    logic [2:0][UW-1:0]       n_u;

    logic signed [RW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;
    logic [1:0]               ai, bi, er_row;
    logic [2:0]               kd;
    logic signed [CW-1:0]     pr;
    logic signed [DW-1:0]     s, sr;

    lan_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (n_start),
        .vec   (n_vec),
        .done  (n_done),
        .zero  (n_zero),
        .u     (n_u)
    );

    // operand order of a cross product: a1*b2, a2*b1, a2*b0, a0*b2, a0*b1, a1*b0
    function automatic logic [1:0] cross_a(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cross_b(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd2;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    assign rows.valid      = ov_reg;
    assign rows.row_index  = oidx_reg;
    assign rows.col0       = oc_reg[0];
    assign rows.col1       = oc_reg[1];
    assign rows.col2       = oc_reg[2];
    assign rows.col3       = oc_reg[3];
    assign rows.degenerate = odeg_reg;
    assign rows.last_row   = olast_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cam_next   = cam_reg;
        up_next    = up_reg;
        fwd_next   = fwd_reg;
        upn_next   = upn_reg;
        right_next = right_reg;
        c_next     = c_reg;
        row_next   = row_reg;
        col3_next  = col3_reg;
        bad_next   = bad_reg;
        prod_next  = prod_reg;
        pv_next    = 1'b0;
        pk_next    = pk_reg;
        pi_next    = pi_reg;
        rk_next    = rk_reg;
        ri_next    = ri_reg;
        acc_next   = acc_reg;
        er_next    = er_reg;
        ov_next    = ov_reg;
        oidx_next  = oidx_reg;
        oc_next    = oc_reg;
        odeg_next  = odeg_reg;
        olast_next = olast_reg;
        job_ready  = 1'b0;
        n_start    = 1'b0;
        n_vec      = '0;
        mul_a      = '0;
        mul_b      = '0;
        ai         = cross_a(cnt_reg[2:0]);
        bi         = cross_b(cnt_reg[2:0]);
        kd         = cnt_reg[2:0] - 3'd1;
        pr         = '0;
        s          = '0;
        sr         = '0;
        er_row     = (er_reg == 2'd3) ? 2'd2 : er_reg;

        if (ov_reg && rows.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            BS_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    cam_next = job.cam;
                    up_next  = job.up;
                    bad_next = 1'b0;
                    n_start  = 1'b1;
                    for (int i = 0; i < 3; i++)
                        n_vec[i] = VW'($signed(job.d[i]));
                    state_next = BS_NFWD;
                end
            end
            BS_NFWD:
            begin
                if (n_done)
                begin
                    fwd_next = n_u;
                    bad_next = bad_reg | n_zero;
                    n_start  = 1'b1;
                    for (int i = 0; i < 3; i++)
                        n_vec[i] = VW'($signed(up_reg[i]));
                    state_next = BS_NUP;
                end
            end
            BS_NUP:
            begin
                if (n_done)
                begin
                    upn_next   = n_u;
                    bad_next   = bad_reg | n_zero;
                    cnt_next   = '0;
                    state_next = BS_X1;
                end
            end
            BS_X1, BS_X2:
            begin
                // issue six products; each is registered and each pair is folded into one component
                if (cnt_reg < 4'd6)
                begin
                    if (state_reg == BS_X1)
                    begin
                        mul_a = RW'($signed(fwd_reg[ai]));
                        mul_b = BW'($signed(upn_reg[bi]));
                    end
                    else
                    begin
                        mul_a = RW'($signed(right_reg[ai]));
                        mul_b = BW'($signed(fwd_reg[bi]));
                    end
                    prod_next = mul_a * mul_b;
                end
                if (cnt_reg != 4'd0 && cnt_reg < 4'd7)
                begin
                    if (!kd[0])
                        c_next[kd[2:1]] = prod_reg[CW-1:0];
                    else
                        c_next[kd[2:1]] = c_reg[kd[2:1]] - prod_reg[CW-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd7)
                begin
                    cnt_next = '0;
                    if (state_reg == BS_X1)
                    begin
                        n_start = 1'b1;
                        for (int i = 0; i < 3; i++)
                            n_vec[i] = VW'($signed(c_reg[i]));
                        state_next = BS_NRIGHT;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            pr = $signed(c_reg[i]) + CW'(1 << (FRAC_BITS - 1));
                            row_next[0][i] = RW'($signed(right_reg[i]));
                            row_next[1][i] = RW'(pr >>> FRAC_BITS);
                            row_next[2][i] = -RW'($signed(fwd_reg[i]));
                        end
                        rk_next    = 2'd0;
                        ri_next    = 2'd0;
                        state_next = BS_DOT;
                    end
                end
            end
            BS_NRIGHT:
            begin
                if (n_done)
                begin
                    right_next = n_u;
                    bad_next   = bad_reg | n_zero;
                    cnt_next   = '0;
                    state_next = BS_X2;
                end
            end
            BS_DOT:
            begin
                if (rk_reg != 2'd3)
                begin
                    mul_a     = $signed(row_reg[rk_reg][ri_reg]);
                    mul_b     = BW'($signed(cam_reg[ri_reg]));
                    prod_next = mul_a * mul_b;
                    pv_next   = 1'b1;
                    pk_next   = rk_reg;
                    pi_next   = ri_reg;
                    if (ri_reg == 2'd2)
                    begin
                        ri_next = 2'd0;
                        rk_next = rk_reg + 1'b1;
                    end
                    else
                    begin
                        ri_next = ri_reg + 1'b1;
                    end
                end
                if (pv_reg)
                begin
                    s = ((pi_reg == 2'd0) ? '0 : acc_reg) + DW'(prod_reg);
                    acc_next = s;
                    if (pi_reg == 2'd2)
                    begin
                        sr = (s + DW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
                        col3_next[pk_reg] = sat_word(-sr);
                        if (pk_reg == 2'd2)
                        begin
                            pv_next    = 1'b0;
                            er_next    = 2'd0;
                            state_next = BS_EMIT;
                        end
                    end
                end
            end
            BS_EMIT:
            begin
                if (!ov_reg || rows.ready)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = er_reg;
                    odeg_next  = bad_reg;
                    olast_next = er_reg == 2'd3;
                    if (er_reg == 2'd3)
                    begin
                        oc_next[0] = '0;
                        oc_next[1] = '0;
                        oc_next[2] = '0;
                        oc_next[3] = sat_word(DW'(1) <<< FRAC_BITS);
                        state_next = BS_IDLE;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            oc_next[i] = sat_word(DW'($signed(row_reg[er_row][i])));
                        oc_next[3] = col3_reg[er_row];
                    end
                    er_next = er_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            ov_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        cam_reg   <= cam_next;
        up_reg    <= up_next;
        fwd_reg   <= fwd_next;
        upn_reg   <= upn_next;
        right_reg <= right_next;
        c_reg     <= c_next;
        row_reg   <= row_next;
        col3_reg  <= col3_next;
        bad_reg   <= bad_next;
        prod_reg  <= prod_next;
        pk_reg    <= pk_next;
        pi_reg    <= pi_next;
        rk_reg    <= rk_next;
        ri_reg    <= ri_next;
        acc_reg   <= acc_next;
        er_reg    <= er_next;
        oidx_reg  <= oidx_next;
        oc_reg    <= oc_next;
        odeg_reg  <= odeg_next;
        olast_reg <= olast_next;
    end

endmodule
`default_nettype wire

### rtl/look_at_view_matrix_top.sv
// the time from input word to first row is dominated by the shared normalize unit:
// three passes of scaling, squares, a 31-step root and three 17-bit divides; two cross
// products and the translations follow. The back takes one item at a time; its four
// rows leave one per cycle from the output register while the sink holds ready high.
// up to three items wait in the front stage and the queue while the back works.
// reset clears valid flags and state machines only, no clearing pass
`default_nettype none
module look_at_view_matrix_top (
    input wire logic clk,
    input wire logic rst_n,
    lan_in_if.sink   points,
    lan_out_if.source rows
);
    import lan_pkg::*;

    job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;

    lan_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .points    (points),
        .job       (f_job),
        .job_valid (f_valid),
        .job_ready (f_ready)
    );

    lan_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (f_job),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_data   (q_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    lan_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_job),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .rows      (rows)
    );

endmodule
`default_nettype wire
